/* rtl/core/mfwq_pkg.sv */
// Package for the mutex with FIFO waiter queue.
// Holds sizes, opcode and status codes, payload structs and controller types.
// No dependencies.
package mfwq_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int TASK_ID_BITS = 8;
  localparam int FILL_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int PTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  typedef enum logic [1:0] {
    OP_LOCK    = 2'd0,
    OP_TRYLOCK = 2'd1,
    OP_UNLOCK  = 2'd2,
    OP_RSVD    = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_RETRY    = 3'd2,
    ST_BUSY     = 3'd3,
    ST_ERROR    = 3'd4,
    ST_RELEASED = 3'd5
  } status_t;

  typedef logic [TASK_ID_BITS-1:0] task_id_t;

  typedef struct packed {
    opcode_t  opcode;
    task_id_t task_id;
  } req_t;

  typedef struct packed {
    status_t  status;
    logic     wake_valid;
    task_id_t wake_task;
    task_id_t current_owner;
  } rsp_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;
    logic exec;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_blocked;
  } dp_stat_t;

endpackage

/* rtl/core/mutex_with_fifo_waiter_queue.sv */
// Top level of the hardware mutex with a FIFO wait queue.
// Instantiates mfwq_ctrl and mfwq_dp; depends on mfwq_pkg.
//
// Each request (lock, trylock, unlock with a task id) is one transfer on the
// req channel and yields exactly one transfer on the rsp channel. A request
// is first captured and then executed against the lock state and the
// waiter queue; a new request is taken only once the last one has executed.
// The queue head is read from a registered memory port, which is what sets
// the capture/execute split. The output register lets the next request be
// captured while a result still waits; execution holds while that register
// is full and not being taken. Lock on a held mutex pushes the caller onto
// a circular queue of QUEUE_DEPTH entries unless its id is zero or the
// queue is full; unlock pops the oldest waiter and reports it in wake_task,
// without making it owner. Unlock does not check the owner. Queue entries
// need no reset: only entries that were pushed are ever popped.
module mutex_with_fifo_waiter_queue import mfwq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  cmd_t     cmd;
  dp_stat_t stat;

  // Sequence capture and execute.
  mfwq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold lock state, queue and result register.
  mfwq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

/* rtl/core/mfwq_ctrl.sv */
// Controller state machine for the mutex unit.
// Sequences capture and execute of one request; depends on mfwq_pkg.
module mfwq_ctrl import mfwq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  dp_stat_t stat,
  output cmd_t     cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (!stat.out_blocked) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
      end
      S_EXEC: begin
        // hold while the output register is full and not being taken
        cmd.exec = !stat.out_blocked;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/mfwq_dp.sv */
// Datapath for the mutex unit: lock state, circular waiter queue, output register.
// Acts on controller commands; depends on mfwq_pkg.
module mfwq_dp import mfwq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  req_t     req,
  input  cmd_t     cmd,
  output dp_stat_t stat,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output rsp_t     rsp
);

  req_t              req_q;
  logic              held, held_next;
  task_id_t          owner, owner_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic [PTR_W-1:0]  head, head_next;
  logic [PTR_W-1:0]  tail, tail_next;
  task_id_t          mem [QUEUE_DEPTH];
  task_id_t          head_data;
  logic              push, pop;
  rsp_t              rsp_next;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end else begin
      return p + PTR_W'(1);
    end
  endfunction

  // Capture the request.
  always_ff @(posedge clk) begin
    if (cmd.capture) req_q <= req;
  end

  // Queue storage; the head entry is read into a register every cycle.
  always_ff @(posedge clk) begin
    if (push) mem[tail] <= req_q.task_id;
    head_data <= mem[head];
  end

  always_comb begin
    held_next  = held;
    owner_next = owner;
    fill_next  = fill;
    head_next  = head;
    tail_next  = tail;
    push       = 1'b0;
    pop        = 1'b0;
    rsp_next.status     = ST_ERROR;
    rsp_next.wake_valid = 1'b0;
    rsp_next.wake_task  = '0;
    unique case (req_q.opcode)
      OP_LOCK: begin
        if (!held) begin
          held_next       = 1'b1;
          owner_next      = req_q.task_id;
          rsp_next.status = ST_GRANTED;
        end else if (req_q.task_id != '0 && fill < FILL_W'(QUEUE_DEPTH)) begin
          push            = cmd.exec;
          rsp_next.status = ST_QUEUED;
        end else begin
          rsp_next.status = ST_RETRY;
        end
      end
      OP_TRYLOCK: begin
        if (!held) begin
          held_next       = 1'b1;
          owner_next      = req_q.task_id;
          rsp_next.status = ST_GRANTED;
        end else begin
          rsp_next.status = ST_BUSY;
        end
      end
      OP_UNLOCK: begin
        if (held) begin
          held_next       = 1'b0;
          owner_next      = '0;
          rsp_next.status = ST_RELEASED;
          if (fill != '0) begin
            pop                 = cmd.exec;
            rsp_next.wake_valid = 1'b1;
            rsp_next.wake_task  = head_data;
          end
        end
      end
      default: ;
    endcase
    if (push) begin
      tail_next = ptr_inc(tail);
      fill_next = fill + FILL_W'(1);
    end
    if (pop) begin
      head_next = ptr_inc(head);
      fill_next = fill - FILL_W'(1);
    end
    rsp_next.current_owner = held_next ? owner_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held  <= 1'b0;
      owner <= '0;
      fill  <= '0;
      head  <= '0;
      tail  <= '0;
    end else if (cmd.exec) begin
      held  <= held_next;
      owner <= owner_next;
      fill  <= fill_next;
      head  <= head_next;
      tail  <= tail_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.exec) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) rsp <= rsp_next;
  end

  assign stat.out_blocked = rsp_valid && !rsp_ready;

endmodule

/* rtl/core/mfwq_checker.sv */
// Port-level checker for the mutex unit, bound to the top level.
// Depends on mfwq_pkg and mutex_with_fifo_waiter_queue.
module mfwq_checker import mfwq_pkg::*; (
  input logic clk,
  input logic rst,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("rsp changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("rsp valid right after reset");

  a_wake_on_release: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.wake_valid |-> rsp.status == ST_RELEASED)
    else $error("wake without release");

  a_release_free: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_RELEASED |-> rsp.current_owner == '0)
    else $error("owner left after release");

  a_no_wake_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.wake_valid |-> rsp.wake_task == '0)
    else $error("wake task set without wake");

endmodule

bind mutex_with_fifo_waiter_queue mfwq_checker u_chk (.*);

/* tb/sv/tb_mutex_with_fifo_waiter_queue.sv */
`timescale 1ns / 1ps
// Self-checking testbench for mutex_with_fifo_waiter_queue.
// Drives lock/trylock/unlock requests; checks each response against a behavioral
// model of the mutex and waiter FIFO or a hand-typed one. Needs mfwq_pkg.
module tb_mutex_with_fifo_waiter_queue;
  import mfwq_pkg::*;

  localparam int RANDOM_REQS    = 400;
  localparam int BLOCK_REQS     = 40;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int MAX_REPORTS    = 10;

  // Traffic mix for one block of random requests.
  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } traffic_mix_t;

  // One scripted request. When pinned is set, pinned_rsp is the response
  // typed in by hand; otherwise the model supplies it.
  typedef struct {
    req_t  req;
    logic  pinned;
    rsp_t  pinned_rsp;
  } scripted_req_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  mutex_with_fifo_waiter_queue i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state: held flag, owner and the FIFO of sleeping waiters.
  logic     mx_held  = 1'b0;
  task_id_t mx_owner = '0;
  task_id_t mx_waiters[$];

  // Scoreboard and run statistics.
  scripted_req_t directed_rows[$];
  scripted_req_t issued_reqs[$];
  rsp_t          owed_rsps[$];
  int            n_errors     = 0;
  int            n_accepted   = 0;
  int            n_responses  = 0;
  int            n_wakes      = 0;
  int            n_full_retry = 0;
  int            peak_waiters = 0;
  int            idle_cycles  = 0;
  int            ready_hold   = 0;
  bit            calm         = 1'b0;

  // Apply one request to the model and return the response it should give.
  task automatic mutex_predict(input req_t r, output rsp_t o);
    o        = '0;
    o.status = ST_ERROR;
    case (r.opcode)
      OP_LOCK: begin
        if (!mx_held) begin
          mx_held  = 1'b1;
          mx_owner = r.task_id;
          o.status = ST_GRANTED;
        end else if (r.task_id != '0 && mx_waiters.size() < QUEUE_DEPTH) begin
          mx_waiters.push_back(r.task_id);
          if (mx_waiters.size() > peak_waiters) peak_waiters = mx_waiters.size();
          o.status = ST_QUEUED;
        end else begin
          if (r.task_id != '0) n_full_retry++;
          o.status = ST_RETRY;
        end
      end
      OP_TRYLOCK: begin
        if (mx_held) begin
          o.status = ST_BUSY;
        end else begin
          mx_held  = 1'b1;
          mx_owner = r.task_id;
          o.status = ST_GRANTED;
        end
      end
      OP_UNLOCK: begin
        // Unlock of a free mutex keeps the error status and changes nothing.
        if (mx_held) begin
          mx_held  = 1'b0;
          mx_owner = '0;
          o.status = ST_RELEASED;
          if (mx_waiters.size() > 0) begin
            o.wake_valid = 1'b1;
            o.wake_task  = mx_waiters.pop_front();
            n_wakes++;
          end
        end
      end
      default: ;
    endcase
    o.current_owner = mx_held ? mx_owner : '0;
  endtask

  // Gap length: mostly zero or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic opcode_t pick_opcode(traffic_mix_t mix);
    int r;
    int lock_w;
    int try_w;
    int unlock_w;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  begin lock_w = 70; try_w = 10; unlock_w = 15; end
      MIX_DRAIN: begin lock_w = 25; try_w = 15; unlock_w = 55; end
      default:   begin lock_w = 45; try_w = 15; unlock_w = 35; end
    endcase
    if (r < lock_w) return OP_LOCK;
    if (r < lock_w + try_w) return OP_TRYLOCK;
    if (r < lock_w + try_w + unlock_w) return OP_UNLOCK;
    return OP_RSVD;
  endfunction

  // Favor a small pool of ids so the same tasks contend, with zero and
  // all-ones mixed in and the full range for the rest.
  function automatic task_id_t pick_task_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 30) return task_id_t'($urandom_range(1, 4));
    if (r < 35) return '1;
    return task_id_t'($urandom_range(0, (1 << TASK_ID_BITS) - 1));
  endfunction

  task automatic add_row(input opcode_t op, input int id, input logic pinned,
                         input status_t st, input logic wv, input int wt,
                         input int own);
    scripted_req_t s;
    s.req.opcode  = op;
    s.req.task_id = task_id_t'(id);
    s.pinned      = pinned;
    s.pinned_rsp  = '{st, wv, task_id_t'(wt), task_id_t'(own)};
    directed_rows.push_back(s);
  endtask

  // Present one request and hold it until the transfer happens. Lower valid
  // only when a gap comes first, so valid never drops and rises in one step.
  task automatic send_request(input scripted_req_t s);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    issued_reqs.push_back(s);
    req       <= s.req;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic note_mismatch(input rsp_t want);
    n_errors++;
    if (n_errors <= MAX_REPORTS) begin
      $display("[%0t] response %0d: status %0d/%0d wake_valid %0b/%0b wake_task %02h/%02h",
               $realtime, n_responses, want.status, rsp.status, want.wake_valid,
               rsp.wake_valid, want.wake_task, rsp.wake_task);
      $display("           current_owner %02h/%02h (expected/actual)",
               want.current_owner, rsp.current_owner);
    end
  endtask

  // Response side: stall in random bursts except during calm blocks.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (ready_hold > 0) begin
      rsp_ready  <= 1'b0;
      ready_hold = ready_hold - 1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      rsp_ready  <= 1'b0;
      ready_hold = pick_gap();
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // Scoreboard: sample both channels at the edge. Predict on every request
  // transfer, then match each response transfer to the oldest expectation.
  scripted_req_t taken;
  rsp_t          model_rsp;
  rsp_t          want;

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) begin
        taken = issued_reqs.pop_front();
        mutex_predict(req, model_rsp);
        owed_rsps.push_back(taken.pinned ? taken.pinned_rsp : model_rsp);
        n_accepted++;
      end
      if (rsp_valid && rsp_ready) begin
        n_responses++;
        if (owed_rsps.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("[%0t] unexpected response: status %0d wake %0b/%02h owner %02h",
                     $realtime, rsp.status, rsp.wake_valid, rsp.wake_task,
                     rsp.current_owner);
        end else begin
          want = owed_rsps.pop_front();
          if (rsp.status !== want.status || rsp.wake_valid !== want.wake_valid ||
              rsp.wake_task !== want.wake_task ||
              rsp.current_owner !== want.current_owner)
            note_mismatch(want);
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
        idle_cycles = 0;
      else
        idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] no transfer for %0d cycles, %0d responses still owed",
                 $realtime, idle_cycles, owed_rsps.size());
        $display("[mutex_with_fifo_waiter_queue] ERROR");
        $finish;
      end
    end
  end

  initial begin
    traffic_mix_t  mix;
    scripted_req_t s;
    int            id;

    // Directed table. Hand-typed responses where the answer is obvious (errors,
    // task id zero, busy, grants, release, queue full); the rest use the model.
    add_row(OP_UNLOCK,  8'h00, 1'b1, ST_ERROR,    1'b0, 0, 8'h00); // unlock while free
    add_row(OP_RSVD,    8'hAA, 1'b1, ST_ERROR,    1'b0, 0, 8'h00); // reserved opcode
    add_row(OP_TRYLOCK, 8'h00, 1'b1, ST_GRANTED,  1'b0, 0, 8'h00); // id zero takes it
    add_row(OP_LOCK,    8'h00, 1'b1, ST_RETRY,    1'b0, 0, 8'h00); // id zero, held
    add_row(OP_TRYLOCK, 8'h55, 1'b1, ST_BUSY,     1'b0, 0, 8'h00);
    add_row(OP_UNLOCK,  8'h55, 1'b1, ST_RELEASED, 1'b0, 0, 8'h00); // no waiters
    add_row(OP_LOCK,    8'hFF, 1'b1, ST_GRANTED,  1'b0, 0, 8'hFF);
    // Fill the waiter FIFO with walking-one and walking-zero ids.
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      id = (1 << (k % 8)) & 8'hFF;
      if ((k / 8) % 2 == 1) id = ~id & 8'hFF;
      add_row(OP_LOCK, id, 1'b0, ST_QUEUED, 1'b0, 0, 0);
    end
    add_row(OP_LOCK,    8'h80, 1'b1, ST_RETRY,    1'b0, 0, 8'hFF); // queue full
    add_row(OP_RSVD,    8'h00, 1'b1, ST_ERROR,    1'b0, 0, 8'hFF); // reserved, held
    add_row(OP_UNLOCK,  8'h7F, 1'b0, ST_RELEASED, 1'b0, 0, 0);     // wakes oldest

    // Hold reset, then release it before the directed requests.
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) send_request(directed_rows[i]);

    // Random part in blocks: each block picks a mix that fills, drains or
    // balances the queue, and some blocks run with no idling at all.
    mix = MIX_EVEN;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % BLOCK_REQS == 0) begin
        mix  = traffic_mix_t'($urandom_range(0, 2));
        calm = ($urandom_range(0, 4) == 0);
      end
      s.req.opcode  = pick_opcode(mix);
      s.req.task_id = pick_task_id();
      s.pinned      = 1'b0;
      s.pinned_rsp  = '0;
      send_request(s);
    end
    calm      = 1'b0;
    req_valid <= 1'b0;

    // Drain: wait for every owed response, then idle on to catch any extra one.
    @(posedge clk);
    while (owed_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests (%0d directed) with %0d responses: %0d wakeups, %0d full-queue retries.",
             n_accepted, directed_rows.size(), n_responses, n_wakes, n_full_retry);
    $display("Waiter FIFO peaked at %0d of %0d; %0d mismatches, %0d responses left owed.",
             peak_waiters, QUEUE_DEPTH, n_errors, owed_rsps.size());
    if (n_errors == 0 && owed_rsps.size() == 0) begin
      $display("[mutex_with_fifo_waiter_queue] OK");
    end else begin
      $display("[mutex_with_fifo_waiter_queue] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/mfwq_pkg.sv
rtl/core/mfwq_ctrl.sv
rtl/core/mfwq_dp.sv
rtl/core/mutex_with_fifo_waiter_queue.sv
rtl/core/mfwq_checker.sv
tb/sv/tb_mutex_with_fifo_waiter_queue.sv
